// File: rtl/phong_pkg.sv
package phong_pkg;

   // Default configuration of the shader
   localparam int DEF_COMPONENT_WIDTH = 16;
   localparam int DEF_POW_TABLE_DEPTH = 256;

   // Pipeline depth from accepted word to result register
   localparam int NUM_STAGES = 15;

   // Bounds of the exp2 search (Q16 values in [1,2))
   localparam logic [63:0] EXP_LO = 64'd65536;
   localparam logic [63:0] EXP_HI = 64'd131071;

   // Base-2 log of a Q30 value in [1,2) by repeated squaring, result Q16
   function automatic logic [15:0] lg_q30(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [15:0] r;
      x = x_arg;
      r = '0;
      for (int k = 15; k >= 0; k--) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            r[k] = 1'b1;
         end
      end
      return r;
   endfunction

   // Smallest Q16 value in [1,2) whose log reaches the target
   function automatic logic [16:0] exp_search(input logic [15:0] target);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = EXP_LO;
      hi = EXP_HI;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (lg_q30(mid << 14) >= target) begin
            hi = mid;
         end else begin
            lo = mid + 64'd1;
         end
      end
      return lo[16:0];
   endfunction

endpackage

// File: rtl/phong_point_light_shader_top.sv
// Phong point-light shader. Each request word carries one surface hit lit by one
// light (light, normal and view vectors in signed Q2.F, diffuse, specular and
// intensity colors in unsigned Q2.F, exponent in Q8.8) and gives one saturated
// RGB response word. The datapath is a 15-stage pipeline: one word is taken every
// cycle when the response side does not stall, and its result is held in the
// last stage's register. A response stall backs up stage by stage, so empty
// stages still fill and req_stall rises only when every stage holds a word. The specular power is
// formed as exp2(e * log2(p)) through two constant tables of POW_TABLE_DEPTH
// entries. The ambient color register is written through the csr port, which
// is always ready; write it only while the pipeline is empty.
module phong_point_light_shader_top #(
   parameter int COMPONENT_WIDTH = phong_pkg::DEF_COMPONENT_WIDTH,
   parameter int POW_TABLE_DEPTH = phong_pkg::DEF_POW_TABLE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [3*COMPONENT_WIDTH-1:0] csr_ambient_color,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [3*COMPONENT_WIDTH-1:0] req_light_dir,
   input  logic [3*COMPONENT_WIDTH-1:0] req_surface_normal,
   input  logic [3*COMPONENT_WIDTH-1:0] req_view_dir,
   input  logic [3*COMPONENT_WIDTH-1:0] req_diffuse_color,
   input  logic [3*COMPONENT_WIDTH-1:0] req_specular_color,
   input  logic [15:0]                  req_spec_exponent,
   input  logic [3*COMPONENT_WIDTH-1:0] req_light_intensity,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [COMPONENT_WIDTH-1:0]   rsp_red_out,
   output logic [COMPONENT_WIDTH-1:0]   rsp_green_out,
   output logic [COMPONENT_WIDTH-1:0]   rsp_blue_out
);

   localparam int W   = COMPONENT_WIDTH;
   localparam int F   = W - 2;
   localparam int NS  = phong_pkg::NUM_STAGES;
   localparam int DW  = 2 * W + 2;      // L.N sum
   localparam int DQ  = DW - F;         // floor(L.N)
   localparam int LW  = DQ - 1;         // lambert, non-negative
   localparam int TW  = 2 * W + 6;      // 2*d*N
   localparam int RW  = W + 9;          // reflected vector component
   localparam int RVW = RW + W;         // R*V product
   localparam int SW  = RVW + 2;        // R.V sum
   localparam int PW  = SW - F;         // power base
   localparam int MW  = $clog2(PW);
   localparam int IW  = (POW_TABLE_DEPTH > 1) ? $clog2(POW_TABLE_DEPTH) : 1;
   localparam int XW  = W + 4;          // power result
   localparam int AW  = 2 * W - F;      // ambient*diffuse
   localparam int LIW = LW + W - F;     // lambert*intensity
   localparam int PSW = XW + W - F;     // pow*specular
   localparam int BW  = LIW + W - F;    // lambert term
   localparam int CW  = PSW + W - F;    // specular term
   localparam int UW  = CW + 2;         // channel sum
   localparam logic [XW-1:0] POW_CAP = '1;
   localparam logic [W-1:0]  CH_MAX  = '1;

   typedef struct packed {
      logic [3*W-1:0] l;
      logic [3*W-1:0] n;
      logic [3*W-1:0] v;
      logic [3*W-1:0] dif;
      logic [3*W-1:0] spc;
      logic [3*W-1:0] ins;
      logic [15:0]    e;
      logic [LW-1:0]  lam;
   } carry_type;

   // Constant log2 / exp2 tables
   logic [15:0] log_rom [POW_TABLE_DEPTH];
   logic [16:0] exp_rom [POW_TABLE_DEPTH];

   for (genvar gi = 0; gi < POW_TABLE_DEPTH; gi++) begin : g_tab
      localparam logic [63:0] LOG_ARG = (64'd1 << 30) + (64'(gi) << 30) / POW_TABLE_DEPTH;
      localparam logic [63:0] EXP_TGT = (64'(gi) << 16) / POW_TABLE_DEPTH;
      assign log_rom[gi] = phong_pkg::lg_q30(LOG_ARG);
      assign exp_rom[gi] = phong_pkg::exp_search(EXP_TGT[15:0]);
   end

   // Ambient register
   logic [3*W-1:0] ambient_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         ambient_ff <= csr_ambient_color;
      end
   end

   // Pipeline flow: a stage loads when empty or when the next one loads
   logic [NS-1:0] valid_ff;
   logic [NS:0]   en;

   always_comb begin
      en[NS] = !rsp_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Operands that travel along the pipeline
   carry_type carry_ff [NS-1];
   carry_type carry_in [NS-1];
   logic [LW-1:0] lam_in;

   always_comb begin
      carry_in[0].l   = req_light_dir;
      carry_in[0].n   = req_surface_normal;
      carry_in[0].v   = req_view_dir;
      carry_in[0].dif = req_diffuse_color;
      carry_in[0].spc = req_specular_color;
      carry_in[0].ins = req_light_intensity;
      carry_in[0].e   = req_spec_exponent;
      carry_in[0].lam = '0;
      for (int s = 1; s < NS - 1; s++) begin
         carry_in[s] = carry_ff[s-1];
      end
      carry_in[1].lam = lam_in;
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS - 1; s++) begin
         if (en[s]) begin
            carry_ff[s] <= carry_in[s];
         end
      end
   end

   // Stage datapath signals
   logic signed [2*W-1:0] lnp_ff [3];
   logic signed [2*W-1:0] lnp_in [3];
   logic signed [DQ-1:0]  d_ff, d_in;
   logic signed [DW-1:0]  dln;
   logic signed [TW-1:0]  t_ff [3];
   logic signed [TW-1:0]  t_in [3];
   logic signed [RW-1:0]  r_ff [3];
   logic signed [RW-1:0]  r_in [3];
   logic signed [RVW-1:0] rvp_ff [3];
   logic signed [RVW-1:0] rvp_in [3];
   logic signed [SW-1:0]  rv_sum;
   logic [PW-1:0]         rv_ff, rv_in;
   logic [MW-1:0]         m_ff, m_in, m7_ff, shl;
   logic [PW-1:0]         norm;
   logic [PW-2:0]         frac_ff, frac_in;
   logic [PW+IW-1:0]      idx_p;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [4:0]            zero_ff;
   logic                  zero_in;
   logic signed [7:0]     mf;
   logic signed [23:0]    log2p_ff, log2p_in;
   logic signed [40:0]    lpe_ff, lpe_in, lpe_a, lpe_b;
   logic signed [16:0]    k_ff, k_in;
   logic [16+IW:0]        fidx_p;
   logic [IW-1:0]         fidx_ff, fidx_in;
   logic signed [17:0]    sh, nsh;
   logic [63:0]           vx, pres;
   logic [XW-1:0]         pw_ff, pw_in;
   logic [2*W-1:0]        ad_p;
   logic [LW+W-1:0]       li_p;
   logic [XW+W-1:0]       ps_p;
   logic [LIW+W-1:0]      b_p;
   logic [PSW+W-1:0]      c_p;
   logic [AW-1:0]         ad_ff [3];
   logic [AW-1:0]         ad_in [3];
   logic [LIW-1:0]        li_ff [3];
   logic [LIW-1:0]        li_in [3];
   logic [PSW-1:0]        ps_ff [3];
   logic [PSW-1:0]        ps_in [3];
   logic [AW-1:0]         a2_ff [3];
   logic [BW-1:0]         b2_ff [3];
   logic [BW-1:0]         b2_in [3];
   logic [CW-1:0]         c2_ff [3];
   logic [CW-1:0]         c2_in [3];
   logic [UW-1:0]         usum [3];
   logic [W-1:0]          out_ff [3];
   logic [W-1:0]          out_in [3];

   // Stages 0-5: L.N, reflection and R.V
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lnp_in[j] = (2*W)'($signed(req_light_dir[j*W +: W]))
                   * (2*W)'($signed(req_surface_normal[j*W +: W]));
      end
      dln = DW'(lnp_ff[0]) + DW'(lnp_ff[1]) + DW'(lnp_ff[2]);
      d_in = DQ'(dln >>> F);
      lam_in = (dln > 0) ? LW'(dln >>> F) : '0;
      for (int j = 0; j < 3; j++) begin
         t_in[j] = (TW'(d_ff) * TW'($signed(carry_ff[1].n[j*W +: W]))) <<< 1;
         r_in[j] = RW'($signed(carry_ff[2].l[j*W +: W])) - RW'(t_ff[j] >>> F);
         rvp_in[j] = RVW'(r_ff[j]) * RVW'($signed(carry_ff[3].v[j*W +: W]));
      end
      rv_sum = SW'(rvp_ff[0]) + SW'(rvp_ff[1]) + SW'(rvp_ff[2]);
      rv_in = (rv_sum > 0) ? PW'(rv_sum >>> F) : '0;
   end

   // Stages 6-11: power through log2 and exp2
   always_comb begin
      m_in = '0;
      for (int i = 0; i < PW; i++) begin
         if (rv_ff[i]) begin
            m_in = MW'(i);
         end
      end
      zero_in = (rv_ff == '0);
      shl = MW'(PW - 1) - m_in;
      norm = rv_ff << shl;
      frac_in = norm[PW-2:0];

      idx_p = (PW+IW)'(frac_ff) * (PW+IW)'(POW_TABLE_DEPTH);
      idx_in = idx_p[PW-1 +: IW];

      mf = 8'(m7_ff) - 8'(F);
      log2p_in = {mf, 16'h0000} + 24'(log_rom[idx_ff]);

      lpe_a = 41'(log2p_ff);
      lpe_b = $signed(41'(carry_ff[8].e));
      lpe_in = lpe_a * lpe_b;

      k_in = 17'(lpe_ff >>> 24);
      fidx_p = (17+IW)'(lpe_ff[23:8]) * (17+IW)'(POW_TABLE_DEPTH);
      fidx_in = fidx_p[16 +: IW];

      sh = 18'(k_ff) + 18'(F) - 18'sd16;
      nsh = -sh;
      vx = 64'(exp_rom[fidx_ff]);
      pres = (sh >= 0) ? (vx << sh[4:0]) : (vx >> nsh[5:0]);
      if (zero_ff[4]) begin
         pw_in = (carry_ff[10].e == 16'h0000) ? (XW'(1) << F) : '0;
      end else if (k_ff > 64 || sh > 30) begin
         pw_in = POW_CAP;
      end else if (k_ff < -128 || sh < -62) begin
         pw_in = '0;
      end else if (pres > 64'(POW_CAP)) begin
         pw_in = POW_CAP;
      end else begin
         pw_in = pres[XW-1:0];
      end
   end

   // Stages 12-14: color terms, sum and saturation
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ad_p = (2*W)'(ambient_ff[j*W +: W]) * (2*W)'(carry_ff[11].dif[j*W +: W]);
         li_p = (LW+W)'(carry_ff[11].lam) * (LW+W)'(carry_ff[11].ins[j*W +: W]);
         ps_p = (XW+W)'(pw_ff) * (XW+W)'(carry_ff[11].spc[j*W +: W]);
         ad_in[j] = ad_p[F +: AW];
         li_in[j] = li_p[F +: LIW];
         ps_in[j] = ps_p[F +: PSW];
         b_p = (LIW+W)'(li_ff[j]) * (LIW+W)'(carry_ff[12].dif[j*W +: W]);
         c_p = (PSW+W)'(ps_ff[j]) * (PSW+W)'(carry_ff[12].ins[j*W +: W]);
         b2_in[j] = b_p[F +: BW];
         c2_in[j] = c_p[F +: CW];
         usum[j] = UW'(a2_ff[j]) + UW'(b2_ff[j]) + UW'(c2_ff[j]);
         out_in[j] = (usum[j] > UW'(CH_MAX)) ? CH_MAX : usum[j][W-1:0];
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (en[0]) lnp_ff <= lnp_in;
      if (en[1]) d_ff <= d_in;
      if (en[2]) t_ff <= t_in;
      if (en[3]) r_ff <= r_in;
      if (en[4]) rvp_ff <= rvp_in;
      if (en[5]) rv_ff <= rv_in;
      if (en[6]) begin
         m_ff       <= m_in;
         frac_ff    <= frac_in;
         zero_ff[0] <= zero_in;
      end
      if (en[7]) begin
         idx_ff     <= idx_in;
         m7_ff      <= m_ff;
         zero_ff[1] <= zero_ff[0];
      end
      if (en[8]) begin
         log2p_ff   <= log2p_in;
         zero_ff[2] <= zero_ff[1];
      end
      if (en[9]) begin
         lpe_ff     <= lpe_in;
         zero_ff[3] <= zero_ff[2];
      end
      if (en[10]) begin
         k_ff       <= k_in;
         fidx_ff    <= fidx_in;
         zero_ff[4] <= zero_ff[3];
      end
      if (en[11]) begin
         pw_ff      <= pw_in;
      end
      if (en[12]) begin
         ad_ff <= ad_in;
         li_ff <= li_in;
         ps_ff <= ps_in;
      end
      if (en[13]) begin
         a2_ff <= ad_ff;
         b2_ff <= b2_in;
         c2_ff <= c2_in;
      end
      if (en[14]) out_ff <= out_in;
   end

   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

   // Input is held back only when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("req_stall raised with an empty stage");

   // No response stall means the pipeline always moves
   a_no_back_pressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req_stall raised without rsp_stall");

   // A csr write lands in the ambient register
   a_csr_write: assert property (@(posedge clock)
      (csr_valid && csr_ready && !reset) |=> (ambient_ff == $past(csr_ambient_color)))
      else $error("ambient register not written");

endmodule

// File: verif/tb_phong_point_light_shader_top.sv
module tb_phong_point_light_shader_top;

   localparam int W     = phong_pkg::DEF_COMPONENT_WIDTH;
   localparam int FB    = W - 2;
   localparam int DEPTH = phong_pkg::DEF_POW_TABLE_DEPTH;
   localparam longint POW_MAX = (longint'(1) << (W + 4)) - 1;
   localparam longint CH_MAX  = (longint'(1) << W) - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [3*W-1:0] light;
      logic [3*W-1:0] normal;
      logic [3*W-1:0] view;
      logic [3*W-1:0] diffuse;
      logic [3*W-1:0] specular;
      logic [15:0]    expo;
      logic [3*W-1:0] intensity;
   } hit_type;

   typedef struct {
      logic [W-1:0] r;
      logic [W-1:0] g;
      logic [W-1:0] b;
   } color_type;

   // Shading predictor plus queue of expected colors
   class shade_scoreboard;
      longint unsigned log_lut[DEPTH];
      longint unsigned exp_lut[DEPTH];
      logic [3*W-1:0]  ambient;
      color_type       color_q[$];
      int              errors;
      int              matched;

      function longint unsigned log2_q30(longint unsigned x_in);
         longint unsigned x;
         longint unsigned r;
         x = x_in;
         r = 0;
         for (int k = 15; k >= 0; k--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
               x = x >> 1;
               r |= 64'd1 << k;
            end
         end
         return r;
      endfunction

      function new();
         longint unsigned target, lo, hi, mid;
         ambient = '0;
         errors  = 0;
         matched = 0;
         for (int i = 0; i < DEPTH; i++) begin
            log_lut[i] = log2_q30((64'd1 << 30) + ((64'(i) << 30) / DEPTH));
            target = (64'(i) << 16) / DEPTH;
            lo = 65536;
            hi = 131071;
            while (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (log2_q30(mid << 14) >= target) hi = mid;
               else lo = mid + 1;
            end
            exp_lut[i] = lo;
         end
      endfunction

      function longint comp_s(logic [3*W-1:0] v, int j);
         logic signed [W-1:0] c;
         c = v[j*W +: W];
         return longint'(c);
      endfunction

      function longint comp_u(logic [3*W-1:0] v, int j);
         logic [W-1:0] c;
         c = v[j*W +: W];
         return longint'(c);
      endfunction

      // base^e via log2/exp2 tables, base Q.FB, e Q8.8
      function longint spec_power(longint p, logic [15:0] e);
         int m;
         longint sh;
         longint unsigned g, idx, fidx;
         longint log2p, z, k, f, v, res;
         if (p <= 0) return (e == 0) ? (longint'(1) << FB) : 0;
         m = 0;
         while (m < 62 && (p >> (m + 1)) != 0) m++;
         g = (64'(p) << (40 - m)) & ((64'd1 << 40) - 1);
         idx = (g * DEPTH) >> 40;
         if (idx >= DEPTH) idx = DEPTH - 1;
         log2p = longint'(m - FB) * 65536 + longint'(log_lut[idx]);
         z = (log2p * longint'(e)) >>> 8;
         k = z >>> 16;
         f = z - k * 65536;
         fidx = (64'(f) * DEPTH) >> 16;
         if (fidx >= DEPTH) fidx = DEPTH - 1;
         v = longint'(exp_lut[fidx]);
         if (k > 64) return POW_MAX;
         if (k < -128) return 0;
         sh = k + FB - 16;
         if (sh >= 0) begin
            if (sh > 30) return POW_MAX;
            res = v << sh;
         end else begin
            if (-sh > 62) return 0;
            res = v >> (-sh);
         end
         return (res > POW_MAX) ? POW_MAX : res;
      endfunction

      // accepted hit: work out its color
      function void note_hit(hit_type h);
         longint dln, lam, d, rv, pw, rr, sum;
         longint chan[3];
         color_type c;
         dln = 0;
         rv  = 0;
         for (int j = 0; j < 3; j++)
            dln += comp_s(h.light, j) * comp_s(h.normal, j);
         lam = (dln > 0) ? (dln >>> FB) : 0;
         d = dln >>> FB;
         for (int j = 0; j < 3; j++) begin
            rr = comp_s(h.light, j) - ((2 * d * comp_s(h.normal, j)) >>> FB);
            rv += rr * comp_s(h.view, j);
         end
         rv = (rv > 0) ? (rv >>> FB) : 0;
         pw = spec_power(rv, h.expo);
         for (int j = 0; j < 3; j++) begin
            sum = (comp_u(ambient, j) * comp_u(h.diffuse, j)) >>> FB;
            sum += (((lam * comp_u(h.intensity, j)) >>> FB) * comp_u(h.diffuse, j)) >>> FB;
            sum += (((pw * comp_u(h.specular, j)) >>> FB) * comp_u(h.intensity, j)) >>> FB;
            chan[j] = (sum > CH_MAX) ? CH_MAX : sum;
         end
         c.r = chan[0][W-1:0];
         c.g = chan[1][W-1:0];
         c.b = chan[2][W-1:0];
         color_q.push_back(c);
      endfunction

      function void check_color(logic [W-1:0] r, logic [W-1:0] g, logic [W-1:0] b);
         color_type c;
         if (color_q.size() == 0) begin
            $error("unexpected response word r=%h g=%h b=%h", r, g, b);
            errors++;
            return;
         end
         c = color_q.pop_front();
         if (r !== c.r) begin
            $error("red_out: expected %h, actual %h", c.r, r);
            errors++;
         end
         if (g !== c.g) begin
            $error("green_out: expected %h, actual %h", c.g, g);
            errors++;
         end
         if (b !== c.b) begin
            $error("blue_out: expected %h, actual %h", c.b, b);
            errors++;
         end
         matched++;
      endfunction
   endclass

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           csr_valid = 1'b0;
   logic           csr_ready;
   logic [3*W-1:0] csr_ambient_color = '0;
   logic           req_valid = 1'b0;
   logic           req_stall;
   logic [3*W-1:0] req_light_dir = '0;
   logic [3*W-1:0] req_surface_normal = '0;
   logic [3*W-1:0] req_view_dir = '0;
   logic [3*W-1:0] req_diffuse_color = '0;
   logic [3*W-1:0] req_specular_color = '0;
   logic [15:0]    req_spec_exponent = '0;
   logic [3*W-1:0] req_light_intensity = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   logic [W-1:0]   rsp_red_out;
   logic [W-1:0]   rsp_green_out;
   logic [W-1:0]   rsp_blue_out;

   shade_scoreboard sb = new();
   int  cycle_count = 0;
   int  hits_sent = 0;
   bit  long_hold = 1'b0;
   bit  no_gaps = 1'b0;

   phong_point_light_shader_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_ambient_color(csr_ambient_color),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_light_dir(req_light_dir), .req_surface_normal(req_surface_normal),
      .req_view_dir(req_view_dir), .req_diffuse_color(req_diffuse_color),
      .req_specular_color(req_specular_color), .req_spec_exponent(req_spec_exponent),
      .req_light_intensity(req_light_intensity),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_color(rsp_red_out, rsp_green_out, rsp_blue_out);
   end

   // response stall generator, with an occasional long hold-off
   initial begin
      int pick;
      int len;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 20);
         end else if (pick < 92) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            len = $urandom_range(5, 40);
         end
         repeat (len) @(posedge clock);
      end
   end

   function automatic logic [3*W-1:0] vec3(int x, int y, int z);
      logic [W-1:0] a, b, c;
      a = x[W-1:0];
      b = y[W-1:0];
      c = z[W-1:0];
      return {c, b, a};
   endfunction

   function automatic logic [3*W-1:0] rand_pack();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   function automatic logic [3*W-1:0] rand_unitish();
      return vec3($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                  $urandom_range(0, 32768) - 16384);
   endfunction

   task automatic send_hit(hit_type h, int gap);
      req_valid           <= 1'b1;
      req_light_dir       <= h.light;
      req_surface_normal  <= h.normal;
      req_view_dir        <= h.view;
      req_diffuse_color   <= h.diffuse;
      req_specular_color  <= h.specular;
      req_spec_exponent   <= h.expo;
      req_light_intensity <= h.intensity;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_hit(h);
      hits_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_ambient(logic [3*W-1:0] v);
      csr_valid         <= 1'b1;
      csr_ambient_color <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.ambient = v;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.color_q.size() != 0) @(posedge clock);
      repeat (phong_pkg::NUM_STAGES + 5) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic hit_type rand_hit();
      hit_type h;
      if ($urandom_range(0, 99) < 80) begin
         h.light  = rand_unitish();
         h.normal = rand_unitish();
         h.view   = rand_unitish();
         h.expo   = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 16'h2000))
                                                : 16'($urandom);
      end else begin
         h.light  = rand_pack();
         h.normal = rand_pack();
         h.view   = rand_pack();
         h.expo   = 16'($urandom);
      end
      h.diffuse   = rand_pack();
      h.specular  = rand_pack();
      h.intensity = rand_pack();
      return h;
   endfunction

   task automatic directed_hits();
      hit_type h;
      logic [3*W-1:0] ones;
      ones = '1;
      // all zero, exponent zero and full
      h = '{'0, '0, '0, '0, '0, 16'h0000, '0};
      send_hit(h, 0);
      h.expo = 16'hFFFF;
      send_hit(h, 1);
      // all ones everywhere
      h = '{ones, ones, ones, ones, ones, 16'hFFFF, ones};
      send_hit(h, 0);
      // mirror highlight: L = N = +z, V = -z, exponent 1.0, then zero, 32.0 and full
      h = '{vec3(0, 0, 16384), vec3(0, 0, 16384), vec3(0, 0, -16384),
            vec3(16384, 8192, 4096), vec3(16384, 16384, 16384), 16'h0100,
            vec3(16384, 16384, 16384)};
      send_hit(h, 0);
      h.expo = 16'h0000;
      send_hit(h, 0);
      h.expo = 16'h2000;
      send_hit(h, 2);
      h.expo = 16'hFFFF;
      send_hit(h, 0);
      // light behind the surface: negative lambert, specular still present
      h = '{vec3(0, 0, -16384), vec3(0, 0, 16384), vec3(0, 0, 16384),
            vec3(16384, 16384, 16384), vec3(16384, 16384, 16384), 16'h0400,
            vec3(16384, 16384, 16384)};
      send_hit(h, 0);
      // zero specular base with nonzero and zero exponent
      h.view = vec3(0, 0, -16384);
      send_hit(h, 0);
      h.expo = 16'h0000;
      send_hit(h, 0);
      // most positive and most negative components, power cap
      h = '{vec3(32767, 32767, 32767), vec3(-32768, -32768, -32768),
            vec3(32767, 32767, 32767), ones, ones, 16'h0800, ones};
      send_hit(h, 0);
      h.view = vec3(-32768, -32768, -32768);
      send_hit(h, 3);
      h.expo = 16'h00FF;
      send_hit(h, 0);
      h = '{vec3(32767, 0, 0), vec3(32767, 0, 0), vec3(-32768, 0, 0),
            ones, ones, 16'h0180, ones};
      send_hit(h, 0);
      // output saturation from diffuse alone
      h = '{vec3(16384, 0, 0), vec3(16384, 0, 0), vec3(0, 16384, 0),
            ones, '0, 16'h0100, ones};
      send_hit(h, 0);
      // fractional exponent and tiny base
      h = '{vec3(100, 0, 16300), vec3(0, 0, 16384), vec3(-90, 20, -16380),
            vec3(8000, 9000, 10000), vec3(5000, 6000, 7000), 16'h0081,
            vec3(12000, 13000, 14000)};
      send_hit(h, 0);
      h.view = vec3(0, 16384, -1);
      send_hit(h, 0);
      h.expo = 16'h0001;
      send_hit(h, 0);
   endtask

   initial begin
      logic [3*W-1:0] amb_set[5];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      amb_set[0] = '0;
      amb_set[1] = '1;
      amb_set[2] = rand_pack();
      amb_set[3] = vec3(16384, 16384, 16384);
      amb_set[4] = rand_pack();

      write_ambient(amb_set[0]);
      directed_hits();
      drain();
      write_ambient(amb_set[1]);
      directed_hits();

      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_ambient(amb_set[ph]);
         no_gaps = (ph == 1);
         for (int i = 0; i < 210; i++) begin
            // phase 2: receiver holds off while the sender keeps offering
            if (ph == 2 && i == 20) long_hold = 1'b1;
            if (ph == 2 && i >= 20 && i < 80) send_hit(rand_hit(), 0);
            else send_hit(rand_hit(), pick_gap());
            // phase 3: sender pauses until every result is back
            if (ph == 3 && i == 100) drain();
         end
      end
      drain();
      $display("Shaded %0d hits over %0d ambient settings; %0d colors checked.",
               hits_sent, 7, sb.matched);
      $display("Covered directed extremes, random well-formed and noise hits, stalls.");
      if (sb.errors == 0 && sb.color_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         if (sb.color_q.size() != 0)
            $error("%0d expected colors never arrived", sb.color_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
